// ===== rtl/wadm_pkg.sv =====
// Shared constants, codes and types of the window alarm dwell monitor.
`default_nettype none
package wadm_pkg;
   localparam int CHANNELS = 16;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LIM_AW   = CH_W + 2;
   localparam int WORD_W   = 32;

   localparam logic [2:0] OP_SAMPLE  = 3'd0;
   localparam logic [2:0] OP_ACK     = 3'd1;
   localparam logic [2:0] OP_ACK_ALL = 3'd2;
   localparam logic [2:0] OP_LIMIT   = 3'd3;
   localparam logic [2:0] OP_LIST    = 3'd4;

   localparam logic [2:0] SEL_CRIT_LO = 3'd0;
   localparam logic [2:0] SEL_CRIT_HI = 3'd1;
   localparam logic [2:0] SEL_WARN_LO = 3'd2;
   localparam logic [2:0] SEL_WARN_HI = 3'd3;
   localparam logic [2:0] SEL_DWELL   = 3'd4;

   localparam logic [1:0] SEV_OK   = 2'd0;
   localparam logic [1:0] SEV_WARN = 2'd1;
   localparam logic [1:0] SEV_CRIT = 2'd2;

   localparam logic [4:0] MAX_LIST = 5'd16;

   // Operand pair for the shared subtractor.
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              signed_op;
   } sub_req_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RD   = 7'b0000010,
      ST_CLS  = 7'b0000100,
      ST_EL   = 7'b0001000,
      ST_DW   = 7'b0010000,
      ST_OUT  = 7'b0100000,
      ST_LIST = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/window_alarm_dwell_monitor_unit.sv =====
// Top level of the multi-channel window alarm monitor with dwell qualification.
`default_nettype none
// The block takes one request word at a time and is not ready until all of its
// result words have been handed to the output register. A sample on an existing
// channel steps through ST_RD, where the four words of its limit memory are
// read, each compared by the one shared subtractor in the cycle after the read,
// then ST_CLS for the class update, ST_EL and ST_DW for two passes through the
// subtractor for the elapsed tick and the dwell compare, and ST_OUT to load the
// result. Acknowledge and limit writes pass through ST_OUT alone. A list scans
// the channels once per severity pass, one channel a cycle while no entry waits
// for the output register to come free. A result word waiting in the output
// register does not stop the sequencer until the next result has to be written.
module window_alarm_dwell_monitor_unit
   import wadm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[2:0], channel[6:3], value[38:7], now_tick[70:39], limit_select[73:71],
   // list_cap[78:74], zero fill[79]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_channel[3:0], active_severity[5:4], raw_severity[7:6],
   // acknowledged[8], worst_severity[10:9], zone_value[42:11], listed[43],
   // zero fill[47:44]
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast
);
   // Request fields.
   logic [2:0]        f_op;
   logic [3:0]        f_ch;
   logic [31:0]       f_value;
   logic [31:0]       f_now;
   logic [2:0]        f_sel;
   logic [4:0]        f_maxc;
   assign f_op    = req_tdata[2:0];
   assign f_ch    = req_tdata[6:3];
   assign f_value = req_tdata[38:7];
   assign f_now   = req_tdata[70:39];
   assign f_sel   = req_tdata[73:71];
   assign f_maxc  = req_tdata[78:74];

   state_type state_ff, state_in;

   // Latched request.
   logic [2:0]        op_ff;
   logic [3:0]        ch_ff;
   logic [CH_W-1:0]   idx_ff;
   logic              in_range_ff;
   logic [31:0]       value_ff;
   logic [31:0]       now_ff;

   // Per-channel state.
   logic [15:0]       dwell_ff  [CHANNELS];
   logic [1:0]        raw_ff    [CHANNELS];
   logic [1:0]        act_ff    [CHANNELS];
   logic [31:0]       zone_ff   [CHANNELS];
   logic [31:0]       cap_ff    [CHANNELS];
   logic [CHANNELS-1:0] ack_ff;

   // Limit memory: four words per channel.
   logic [31:0]       limit_mem [4*CHANNELS];
   logic [31:0]       rd_ff;

   // Sequencer working registers.
   logic [2:0]        k_ff;
   logic [3:0]        flag_ff;   // crit low, crit high, warn low, warn high
   logic [1:0]        cls_ff;
   logic [31:0]       el_ff;
   logic [CH_W:0]     scan_ff;
   logic [4:0]        n_ff;
   logic [4:0]        total_ff;

   logic              rsp_valid_ff;
   logic [47:0]       rsp_data_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              slot_free;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Worst active severity and the active masks for list sizing.
   logic [CHANNELS-1:0] crit_mask, warn_mask;
   logic [1:0]          worst;
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         crit_mask[i] = (act_ff[i] == SEV_CRIT);
         warn_mask[i] = (act_ff[i] == SEV_WARN);
      end
      if (|crit_mask) begin
         worst = SEV_CRIT;
      end else if (|warn_mask) begin
         worst = SEV_WARN;
      end else begin
         worst = SEV_OK;
      end
   end

   logic [4:0] active_cnt, maxc_sat, total_in;
   always_comb begin
      active_cnt = 5'($countones(crit_mask | warn_mask));
      maxc_sat   = (f_maxc > MAX_LIST) ? MAX_LIST : f_maxc;
      total_in   = (active_cnt < maxc_sat) ? active_cnt : maxc_sat;
   end

   // Shared subtractor: limit compare in ST_RD, tick math in ST_EL and ST_DW.
   sub_req_type     sub_req;
   logic [WORD_W:0] sub_diff;
   always_comb begin
      sub_req.a         = value_ff;
      sub_req.b         = rd_ff;
      sub_req.signed_op = 1'b1;
      if (state_ff == ST_EL) begin
         sub_req.a         = now_ff;
         sub_req.b         = zone_ff[idx_ff];
         sub_req.signed_op = 1'b0;
      end else if (state_ff == ST_DW) begin
         sub_req.a         = el_ff;
         sub_req.b         = {16'd0, dwell_ff[idx_ff]};
         sub_req.signed_op = 1'b0;
      end
   end

   wadm_sub u_sub (
      .req  (sub_req),
      .diff (sub_diff)
   );

   logic below, above;
   assign below = sub_diff[WORD_W];
   assign above = !sub_diff[WORD_W] && (sub_diff != '0);

   // Class from the four window flags.
   logic [1:0] cls_in;
   always_comb begin
      priority if (flag_ff[0] || flag_ff[1]) begin
         cls_in = SEV_CRIT;
      end else if (flag_ff[2] || flag_ff[3]) begin
         cls_in = SEV_WARN;
      end else begin
         cls_in = SEV_OK;
      end
   end

   // List scan position.
   logic [CH_W-1:0] scan_ch;
   logic            scan_hit;
   logic            scan_end;
   assign scan_ch  = scan_ff[CH_W-1:0];
   assign scan_hit = (act_ff[scan_ch] == (scan_ff[CH_W] ? SEV_WARN : SEV_CRIT));
   assign scan_end = (n_ff + 5'd1 == total_ff);

   // Result words built for a single-channel item, a list entry and an empty list.
   logic [47:0] single_word, entry_word, empty_word;
   always_comb begin
      single_word = '0;
      single_word[3:0]  = ch_ff;
      single_word[10:9] = worst;
      if (in_range_ff) begin
         single_word[5:4]   = act_ff[idx_ff];
         single_word[7:6]   = raw_ff[idx_ff];
         single_word[8]     = ack_ff[idx_ff];
         single_word[42:11] = cap_ff[idx_ff];
      end
      entry_word = '0;
      entry_word[3:0]   = 4'(scan_ch);
      entry_word[5:4]   = act_ff[scan_ch];
      entry_word[7:6]   = raw_ff[scan_ch];
      entry_word[8]     = ack_ff[scan_ch];
      entry_word[10:9]  = worst;
      entry_word[42:11] = cap_ff[scan_ch];
      entry_word[43]    = 1'b1;
      empty_word = '0;
      empty_word[10:9]  = worst;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (f_op == OP_SAMPLE) begin
                  state_in = (32'(f_ch) < CHANNELS) ? ST_RD : ST_OUT;
               end else if (f_op == OP_LIST) begin
                  state_in = (total_in == 5'd0) ? ST_OUT : ST_LIST;
               end else if (f_op < OP_LIST) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD:   state_in = (k_ff == 3'd4) ? ST_CLS : ST_RD;
         ST_CLS:  state_in = ST_EL;
         ST_EL:   state_in = ST_DW;
         ST_DW:   state_in = ST_OUT;
         ST_OUT:  state_in = slot_free ? ST_IDLE : ST_OUT;
         ST_LIST: state_in = (scan_hit && slot_free && scan_end) ? ST_IDLE : ST_LIST;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Limit memory port: one write at accept, one registered read in ST_RD.
   always_ff @(posedge clock) begin
      if (accept && f_op == OP_LIMIT && f_sel < SEL_DWELL && 32'(f_ch) < CHANNELS) begin
         limit_mem[{f_ch[CH_W-1:0], f_sel[1:0]}] <= f_value;
      end
      if (state_ff == ST_RD) begin
         rd_ff <= limit_mem[{idx_ff, k_ff[1:0]}];
      end
   end

   // Request latch, sequencer registers and dwell table.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= f_op;
         ch_ff       <= f_ch;
         idx_ff      <= f_ch[CH_W-1:0];
         in_range_ff <= (32'(f_ch) < CHANNELS);
         value_ff    <= f_value;
         now_ff      <= f_now;
         k_ff        <= 3'd0;
         scan_ff     <= '0;
         n_ff        <= 5'd0;
         total_ff    <= total_in;
         if (f_op == OP_LIMIT && f_sel == SEL_DWELL && 32'(f_ch) < CHANNELS) begin
            dwell_ff[f_ch[CH_W-1:0]] <= f_value[15:0];
         end
      end
      if (state_ff == ST_RD) begin
         k_ff <= k_ff + 3'd1;
         // Compare the word read in the previous cycle.
         unique case (k_ff)
            3'd1:    flag_ff[0] <= below;
            3'd2:    flag_ff[1] <= above;
            3'd3:    flag_ff[2] <= below;
            3'd4:    flag_ff[3] <= above;
            default: ;
         endcase
      end
      if (state_ff == ST_CLS) begin
         cls_ff <= cls_in;
      end
      if (state_ff == ST_EL) begin
         el_ff <= sub_diff[31:0];
      end
      if (state_ff == ST_LIST) begin
         if (!scan_hit) begin
            scan_ff <= scan_ff + {{CH_W{1'b0}}, 1'b1};
         end else if (slot_free) begin
            scan_ff <= scan_ff + {{CH_W{1'b0}}, 1'b1};
            n_ff    <= n_ff + 5'd1;
         end
      end
   end

   // Channel status registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            raw_ff[i]  <= SEV_OK;
            act_ff[i]  <= SEV_OK;
            zone_ff[i] <= '0;
            cap_ff[i]  <= '0;
         end
      end else begin
         if (accept && f_op == OP_ACK_ALL) begin
            ack_ff <= '1;
         end else if (accept && f_op == OP_ACK && 32'(f_ch) < CHANNELS) begin
            ack_ff[f_ch[CH_W-1:0]] <= 1'b1;
         end
         // A change of raw class restarts the dwell timer.
         if (state_ff == ST_CLS && cls_in != raw_ff[idx_ff]) begin
            raw_ff[idx_ff]  <= cls_in;
            zone_ff[idx_ff] <= now_ff;
            cap_ff[idx_ff]  <= value_ff;
            if (cls_in == SEV_OK) begin
               ack_ff[idx_ff] <= 1'b0;
            end
         end
         // Elapsed ticks at or beyond the dwell qualify the class.
         if (state_ff == ST_DW && !sub_diff[WORD_W]) begin
            act_ff[idx_ff] <= cls_ff;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (state_ff == ST_LIST && scan_hit && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && slot_free) begin
         rsp_data_ff <= (op_ff == OP_LIST) ? empty_word : single_word;
         rsp_last_ff <= 1'b1;
      end else if (state_ff == ST_LIST && scan_hit && slot_free) begin
         rsp_data_ff <= entry_word;
         rsp_last_ff <= scan_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule
`default_nettype wire

// ===== rtl/wadm_sub.sv =====
// Shared 33-bit subtractor used for limit compares and tick arithmetic.
`default_nettype none
module wadm_sub
   import wadm_pkg::*;
(
   input  sub_req_type     req,
   output logic [WORD_W:0] diff
);
   logic [WORD_W:0] a_ext;
   logic [WORD_W:0] b_ext;

   // Sign or zero extension picks signed or unsigned ordering of the borrow.
   assign a_ext = {req.signed_op & req.a[WORD_W-1], req.a};
   assign b_ext = {req.signed_op & req.b[WORD_W-1], req.b};
   assign diff  = a_ext - b_ext;
endmodule
`default_nettype wire

// ===== rtl/wadm_checker.sv =====
// Port-level checks of the window alarm dwell monitor and their bind.
`default_nettype none
module wadm_checker
   import wadm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [79:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // A defined op keeps the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[2:0] <= OP_LIST) |=> !req_tready)
      else $error("ready right after a defined op");

   // A listed channel is active.
   a_list: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[43] |-> rsp_tdata[5:4] != SEV_OK)
      else $error("listed channel not active");

   // Worst severity is never below a reported active severity.
   a_worst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:9] >= rsp_tdata[5:4] && rsp_tdata[10:9] <= SEV_CRIT)
      else $error("worst severity inconsistent");
endmodule

bind window_alarm_dwell_monitor_unit wadm_checker u_wadm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
